### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the vertex deformer checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SVD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spherize deformer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SVD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spherize deformer assertion failed");

`endif

### sv/svd_pkg.sv
// ---------------------------------------------------------------------------
// Spherize deformer package
// Shared widths, constants, cell data types and helpers.
// ---------------------------------------------------------------------------
package svd_pkg;

    localparam int FIELD_W         = 32;
    localparam int WEIGHT_W        = 17;
    localparam int RADIUS_W        = 31;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 32;
    localparam int COORD_WIDTH_DEF = 32;

    // One root bit per cell, one quotient bit per cell.
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 33;

    localparam logic [WEIGHT_W-1:0] ONE_Q16    = 17'h10000;
    localparam logic [RADIUS_W-1:0] RADIUS_RST = 31'h10000;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BULGE    = 2'd0,
        REG_RADIUS   = 2'd1,
        REG_ENVELOPE = 2'd2
    } cfg_reg_t;

    // State handed along the square root chain.
    typedef struct packed {
        logic [63:0] rad;
        logic [33:0] rem;
        logic [31:0] root;
    } sqrt_step_t;

    // State handed along a divider chain: partial remainder and a shift word
    // that holds the numerator bits still to come and the quotient so far.
    typedef struct packed {
        logic [31:0] rem;
        logic [32:0] low;
    } div_step_t;

    // Magnitude of a signed coordinate; the most negative value maps to 2^31.
    function automatic logic [31:0] mag32(logic signed [31:0] v);
        logic [31:0] neg;
        neg = 32'(-v);
        return v[31] ? neg : v;
    endfunction

endpackage

### sv/svd_sqrt_cell.sv
// ---------------------------------------------------------------------------
// Square root cell
// One digit step of the integer square root, registered.
// ---------------------------------------------------------------------------
module svd_sqrt_cell (
    input  logic                clk,
    input  logic                en,
    input  svd_pkg::sqrt_step_t d,
    output svd_pkg::sqrt_step_t q
);
    import svd_pkg::*;

    logic [35:0] rem_s;
    logic [35:0] trial;
    logic        ge;
    logic [35:0] diff;
    sqrt_step_t  q_next;
    sqrt_step_t  q_reg;

    // Bring in two radicand bits and try the next root bit.
    always_comb
    begin
        rem_s = {d.rem, d.rad[63:62]};
        trial = {2'b00, d.root, 2'b01};
        ge    = (rem_s >= trial);
        diff  = rem_s - trial;
        q_next.rem  = ge ? diff[33:0] : rem_s[33:0];
        q_next.root = {d.root[30:0], ge};
        q_next.rad  = {d.rad[61:0], 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

### sv/svd_div_cell.sv
// ---------------------------------------------------------------------------
// Divider cell
// One restoring division step, producing one quotient bit, registered.
// ---------------------------------------------------------------------------
module svd_div_cell (
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        divisor,
    input  svd_pkg::div_step_t d,
    output svd_pkg::div_step_t q
);
    import svd_pkg::*;

    logic [32:0] rem_s;
    logic [32:0] diff;
    logic        ge;
    div_step_t   q_next;
    div_step_t   q_reg;

    // Shift in the next numerator bit and subtract the divisor if it fits.
    always_comb
    begin
        rem_s = {d.rem, d.low[32]};
        diff  = rem_s - {1'b0, divisor};
        ge    = (rem_s >= {1'b0, divisor});
        q_next.rem = ge ? diff[31:0] : rem_s[31:0];
        q_next.low = {d.low[31:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

### sv/spherize_vertex_deform.sv
// Throughput: one vertex per cycle unless a finished result is stalled;
// the 32-cell root chain and the 33-cell divider chains each take a new
// vertex every cycle while the pipe advances.
// Reset clears all stage valid bits and loads the configuration defaults.
// ---------------------------------------------------------------------------
// Spherize vertex deformer
// Pushes each vertex toward a sphere by distance, root and division chains.
// ---------------------------------------------------------------------------
module spherize_vertex_deform #(
    parameter int COORD_WIDTH = svd_pkg::COORD_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [svd_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [svd_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [svd_pkg::FIELD_W-1:0]     pos_x,
    input  logic signed [svd_pkg::FIELD_W-1:0]     pos_y,
    input  logic signed [svd_pkg::FIELD_W-1:0]     pos_z,
    input  logic [svd_pkg::WEIGHT_W-1:0]           vertex_weight,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [svd_pkg::FIELD_W-1:0]     new_x,
    output logic signed [svd_pkg::FIELD_W-1:0]     new_y,
    output logic signed [svd_pkg::FIELD_W-1:0]     new_z
);
    import svd_pkg::*;

    localparam int EFF_W   = (COORD_WIDTH < 16) ? 16 :
                             ((COORD_WIDTH > FIELD_W) ? FIELD_W : COORD_WIDTH);
    localparam int SEXT_SH = FIELD_W - EFF_W;
    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (EFF_W - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

    // Stage positions along the pipe.
    localparam int IDX_S0  = 0;
    localparam int IDX_S1  = IDX_S0 + 1;
    localparam int IDX_S2  = IDX_S1 + 1;
    localparam int IDX_S3  = IDX_S2 + SQRT_STEPS + 1;
    localparam int IDX_S4  = IDX_S3 + 1;
    localparam int IDX_S5  = IDX_S4 + 1;
    localparam int IDX_S6  = IDX_S5 + DIV_STEPS + 1;
    localparam int IDX_S7  = IDX_S6 + 1;
    localparam int IDX_OUT = IDX_S7 + 1;
    localparam int NSTAGES = IDX_OUT + 1;

    typedef struct packed {
        logic [2:0][FIELD_W-1:0]  pos;
        logic [WEIGHT_W-1:0]      gain;
    } side_t;

    // Configuration registers.
    logic [WEIGHT_W-1:0] bulge_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic [WEIGHT_W-1:0] env_reg;
    logic [WEIGHT_W-1:0] a_cap;
    logic [WEIGHT_W-1:0] inv_a;
    logic [WEIGHT_W-1:0] e_cap;
    logic [WEIGHT_W-1:0] w_cap;

    logic                   adv;
    logic [NSTAGES-1:0]     vld_reg;
    side_t                  side_reg [NSTAGES];
    logic [31:0]            len_reg  [IDX_S3:IDX_S7];

    logic signed [FIELD_W-1:0] x_ext;
    logic signed [FIELD_W-1:0] y_ext;
    logic signed [FIELD_W-1:0] z_ext;
    logic [33:0]               g_full;

    logic [63:0]  sq_reg   [3];
    sqrt_step_t   sq_in_reg;
    sqrt_step_t   sq_out   [SQRT_STEPS];
    logic [47:0]  pa_reg;
    logic [48:0]  pb_reg;
    logic [49:0]  dist_sum;
    logic [32:0]  dist_reg;
    logic [63:0]  num      [3];
    div_step_t    dv_in_reg [3];
    div_step_t    dv_out   [3][DIV_STEPS];
    logic signed [33:0] t_val  [3];
    logic signed [34:0] diff_reg [3];
    logic signed [52:0] prod_reg [3];
    logic signed [52:0] adj    [3];
    logic signed [53:0] total  [3];
    logic signed [FIELD_W-1:0] res   [3];
    logic signed [FIELD_W-1:0] new_reg [3];

    // The whole pipe moves unless a finished result is waiting.
    assign adv       = !vld_reg[IDX_OUT] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[IDX_OUT];
    assign cfg_ready = 1'b1;

    // Configuration write port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bulge_reg  <= '0;
            radius_reg <= RADIUS_RST;
            env_reg    <= ONE_Q16;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_BULGE:    bulge_reg  <= cfg_data[WEIGHT_W-1:0];
                REG_RADIUS:   radius_reg <= cfg_data[RADIUS_W-1:0];
                REG_ENVELOPE: env_reg    <= cfg_data[WEIGHT_W-1:0];
                default:      ;
            endcase
        end
    end

    // Amounts above one count as one.
    always_comb
    begin
        a_cap = (bulge_reg > ONE_Q16) ? ONE_Q16 : bulge_reg;
        e_cap = (env_reg > ONE_Q16) ? ONE_Q16 : env_reg;
        w_cap = (vertex_weight > ONE_Q16) ? ONE_Q16 : vertex_weight;
        inv_a = ONE_Q16 - a_cap;
        x_ext = $signed(pos_x <<< SEXT_SH) >>> SEXT_SH;
        y_ext = $signed(pos_y <<< SEXT_SH) >>> SEXT_SH;
        z_ext = $signed(pos_z <<< SEXT_SH) >>> SEXT_SH;
        g_full = {17'b0, e_cap} * {17'b0, side_reg[IDX_S0].gain};
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTAGES-2:0], in_valid};
        end
    end

    // Input capture: coordinates sign-extended, weight capped.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[IDX_S0].pos[0] <= x_ext;
            side_reg[IDX_S0].pos[1] <= y_ext;
            side_reg[IDX_S0].pos[2] <= z_ext;
            side_reg[IDX_S0].gain   <= w_cap;
        end
    end

    // Squares of the magnitudes; gain becomes envelope times weight.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                sq_reg[a] <= {32'b0, mag32(side_reg[IDX_S0].pos[a])} *
                             {32'b0, mag32(side_reg[IDX_S0].pos[a])};
            end
            side_reg[IDX_S1].pos  <= side_reg[IDX_S0].pos;
            side_reg[IDX_S1].gain <= g_full[32:16];
        end
    end

    // Side data shift line for the remaining stages.
    for (genvar i = IDX_S2; i < NSTAGES; i++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Squared length, loaded into the root chain.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_in_reg.rad  <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            sq_in_reg.rem  <= '0;
            sq_in_reg.root <= '0;
        end
    end

    // Root chain: one result bit per cell.
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        if (k == 0)
        begin : g_first
            svd_sqrt_cell u_cell (
                .clk (clk),
                .en  (adv),
                .d   (sq_in_reg),
                .q   (sq_out[k])
            );
        end
        else
        begin : g_next
            svd_sqrt_cell u_cell (
                .clk (clk),
                .en  (adv),
                .d   (sq_out[k-1]),
                .q   (sq_out[k])
            );
        end
    end

    // Length shift line up to the final stage.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            len_reg[IDX_S3] <= sq_out[SQRT_STEPS-1].root;
        end
    end

    for (genvar i = IDX_S3 + 1; i <= IDX_S7; i++)
    begin : g_len
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                len_reg[i] <= len_reg[i-1];
            end
        end
    end

    // Target distance terms, then their sum scaled back to Q16.16.
    assign dist_sum = {2'b00, pa_reg} + {1'b0, pb_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg   <= {31'b0, a_cap} * {17'b0, radius_reg};
            pb_reg   <= {32'b0, inv_a} * {17'b0, sq_out[SQRT_STEPS-1].root};
            dist_reg <= dist_sum[48:16];
        end
    end

    // Numerators for the target components.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            num[a] = {32'b0, mag32(side_reg[IDX_S4].pos[a])} * {31'b0, dist_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                dv_in_reg[a].rem <= {1'b0, num[a][63:33]};
                dv_in_reg[a].low <= num[a][32:0];
            end
        end
    end

    // Divider chains, one per axis, one quotient bit per cell.
    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        for (genvar k = 0; k < DIV_STEPS; k++)
        begin : g_div
            if (k == 0)
            begin : g_first
                svd_div_cell u_cell (
                    .clk     (clk),
                    .en      (adv),
                    .divisor (len_reg[IDX_S5 + k]),
                    .d       (dv_in_reg[a]),
                    .q       (dv_out[a][k])
                );
            end
            else
            begin : g_next
                svd_div_cell u_cell (
                    .clk     (clk),
                    .en      (adv),
                    .divisor (len_reg[IDX_S5 + k]),
                    .d       (dv_out[a][k-1]),
                    .q       (dv_out[a][k])
                );
            end
        end
    end

    // Signed target and its offset from the original coordinate.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            t_val[a] = side_reg[IDX_S6-1].pos[a][FIELD_W-1] ?
                       -$signed({1'b0, dv_out[a][DIV_STEPS-1].low}) :
                        $signed({1'b0, dv_out[a][DIV_STEPS-1].low});
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                diff_reg[a] <= 35'(t_val[a]) - 35'($signed(side_reg[IDX_S6-1].pos[a]));
                prod_reg[a] <= diff_reg[a] * $signed({1'b0, side_reg[IDX_S6].gain});
            end
        end
    end

    // Scale toward zero, add back the coordinate and saturate; a zero length gives zero.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            adj[a]   = prod_reg[a] + (prod_reg[a][52] ? 53'sd65535 : 53'sd0);
            total[a] = 54'($signed(side_reg[IDX_S7].pos[a])) + 54'(adj[a] >>> 16);
            if (len_reg[IDX_S7] == '0)
            begin
                res[a] = '0;
            end
            else if (64'(total[a]) > SAT_HI)
            begin
                res[a] = SAT_HI[FIELD_W-1:0];
            end
            else if (64'(total[a]) < SAT_LO)
            begin
                res[a] = SAT_LO[FIELD_W-1:0];
            end
            else
            begin
                res[a] = total[a][FIELD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                new_reg[a] <= res[a];
            end
        end
    end

    assign new_x = new_reg[0];
    assign new_y = new_reg[1];
    assign new_z = new_reg[2];

endmodule

### sv/svd_checker.sv
// ---------------------------------------------------------------------------
// Spherize deformer port checker
// Watches the handshake ports of the deformer over time.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module svd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] new_x,
    input logic [31:0] new_y,
    input logic [31:0] new_z
);
    // A stalled result stays offered.
    `SVD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    // A stalled result keeps its value.
    `SVD_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(new_x) && $stable(new_y) && $stable(new_z))
    // With no result pending the block always takes a transaction.
    `SVD_ASSERT_NOW(a_in_free, clk, rst_n, !out_valid, in_ready)
    // When the consumer is ready the pipe keeps moving.
    `SVD_ASSERT_NOW(a_in_flow, clk, rst_n, out_ready, in_ready)

endmodule

bind spherize_vertex_deform svd_checker u_svd_checker (.*);

### bench/spherize_vertex_deform_test.sv
// ---------------------------------------------------------------------------
// Spherize vertex deformer testbench
// Streams vertices through the deformer under several register settings and
// random handshake gaps, and checks every deformed vertex against a predictor.
// ---------------------------------------------------------------------------
module spherize_vertex_deform_test;

    import svd_pkg::*;

    localparam int LATENCY     = 73;
    localparam int CYCLE_LIMIT = 600000;

    // Expected deformed vertex.
    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vertex_t;

    // Scoreboard: predicts deformed vertices and matches them in order.
    class deform_scoreboard;
        vertex_t pending[$];
        int      errors;
        logic [16:0] bulge;
        logic [30:0] radius;
        logic [16:0] envelope;

        function new();
            errors   = 0;
            bulge    = 17'd0;
            radius   = 31'h10000;
            envelope = 17'h10000;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [31:0] data);
            case (idx)
                REG_BULGE:    bulge = data[16:0];
                REG_RADIUS:   radius = data[30:0];
                REG_ENVELOPE: envelope = data[16:0];
                default: ;
            endcase
        endfunction

        static function logic [63:0] root64(logic [63:0] n);
            logic [63:0] res;
            logic [63:0] b;
            res = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0)
            begin
                if (n >= res + b)
                begin
                    n = n - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        static function logic signed [31:0] shift_axis(logic signed [63:0] c,
            logic [63:0] reach, logic [63:0] len, logic [63:0] g);
            logic [63:0] mc;
            logic [63:0] tm;
            logic signed [63:0] t;
            logic signed [63:0] v;
            mc = c < 0 ? -c : c;
            tm = (mc * reach) / len;
            t = c < 0 ? -$signed(tm) : $signed(tm);
            v = c + ((t - c) * $signed(g)) / 64'sd65536;
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            return v[31:0];
        endfunction

        // Note an accepted input vertex.
        function void note_vertex(logic signed [31:0] px, logic signed [31:0] py,
            logic signed [31:0] pz, logic [16:0] w);
            vertex_t r;
            logic signed [63:0] x, y, z;
            logic [63:0] a, e, wc, len, reach, g;
            x = px; y = py; z = pz;
            wc = w > 17'h10000 ? 64'd65536 : 64'(w);
            a = bulge > 17'h10000 ? 64'd65536 : 64'(bulge);
            e = envelope > 17'h10000 ? 64'd65536 : 64'(envelope);
            len = root64(64'(x * x) + 64'(y * y) + 64'(z * z));
            r.x = 0; r.y = 0; r.z = 0;
            if (len != 0)
            begin
                reach = (a * 64'(radius) + (64'd65536 - a) * len) >> 16;
                g = (e * wc) >> 16;
                r.x = shift_axis(x, reach, len, g);
                r.y = shift_axis(y, reach, len, g);
                r.z = shift_axis(z, reach, len, g);
            end
            pending.push_back(r);
        endfunction

        // Check one accepted output vertex.
        function void check_vertex(logic signed [31:0] nx, logic signed [31:0] ny,
            logic signed [31:0] nz);
            vertex_t r;
            if (pending.size() == 0)
            begin
                $error("unexpected output vertex %0d %0d %0d", nx, ny, nz);
                errors++;
                return;
            end
            r = pending.pop_front();
            if (nx !== r.x) begin $error("new_x expected %0d got %0d", r.x, nx); errors++; end
            if (ny !== r.y) begin $error("new_y expected %0d got %0d", r.y, ny); errors++; end
            if (nz !== r.z) begin $error("new_z expected %0d got %0d", r.z, nz); errors++; end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic [16:0] vertex_weight;
    logic out_valid;
    logic out_ready;
    logic signed [31:0] new_x, new_y, new_z;

    deform_scoreboard sb;
    int  cycles;
    bit  stall_long;

    spherize_vertex_deform u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .vertex_weight(vertex_weight),
        .out_valid(out_valid), .out_ready(out_ready),
        .new_x(new_x), .new_y(new_y), .new_z(new_z)
    );

    // Clock.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Cycle counter and timeout.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Write one register as a configuration transaction.
    task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Send one vertex transaction, after a random gap when gaps is set.
    task automatic send_vertex(logic signed [31:0] px, logic signed [31:0] py,
        logic signed [31:0] pz, logic [16:0] w, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 18) : 0;
        if (gaps && $urandom_range(0, 3) == 0) gap = 0;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid = 1'b1;
        pos_x = px; pos_y = py; pos_z = pz; vertex_weight = w;
        do @(posedge clk); while (!in_ready);
        sb.note_vertex(px, py, pz, w);
    endtask

    task automatic end_burst();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Wait until every expected vertex has come back.
    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
            2: return $signed($urandom_range(0, 32'h1ffffff)) - 32'sh1000000;
            3: return 32'sh0;
            4: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
        endcase
    endfunction

    function automatic logic [16:0] rand_weight();
        case ($urandom_range(0, 3))
            0: return 17'h10000;
            1: return $urandom_range(17'h10000, 17'h1ffff);
            default: return $urandom_range(0, 17'hffff);
        endcase
    endfunction

    // Random phase under one register setting.
    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_weight(),
                        (i % 80) < 50);
        end_burst();
        drain();
    endtask

    // Receiver: random stalls plus one long hold-off.
    initial
    begin
        int wait_n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_long)
            begin
                out_ready = 1'b0;
                repeat (300) @(negedge clk);
                stall_long = 1'b0;
            end
            wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
            out_ready = 1'b0;
            repeat (wait_n) @(negedge clk);
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_vertex(new_x, new_y, new_z);
        end
    end

    // Stimulus.
    initial
    begin
        sb = new();
        cycles = 0;
        stall_long = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_BULGE;
        cfg_data = '0;
        in_valid = 1'b0;
        pos_x = 0; pos_y = 0; pos_z = 0;
        vertex_weight = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset settings, field extremes, zero-length vertex.
        send_vertex(0, 0, 0, 17'h10000, 0);
        send_vertex(32'sh10000, 0, 0, 17'h10000, 0);
        send_vertex(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 17'h1ffff, 0);
        send_vertex(32'sh80000000, 32'sh80000000, 32'sh80000000, 17'h10000, 0);
        send_vertex(-32'sh10000, 32'sh20000, -32'sh30000, 17'h0, 0);
        send_vertex(1, -1, 1, 17'h8000, 0);
        end_burst();
        drain();
        write_reg(REG_BULGE, 32'h10000);
        write_reg(REG_RADIUS, 32'h7fffffff);
        write_reg(REG_ENVELOPE, 32'h10000);
        send_vertex(0, 0, 0, 17'h10000, 0);
        send_vertex(32'sh10000, 32'sh10000, 0, 17'h10000, 0);
        send_vertex(32'sh80000000, 0, 1, 17'h1ffff, 0);
        send_vertex(-5, 7, 32'sh7fffffff, 17'h10000, 0);
        send_vertex(-32'sh123456, 32'sh654321, 32'sh1000, 17'h4000, 0);
        end_burst();
        drain();
        write_reg(REG_BULGE, 32'hffffffff);
        write_reg(REG_RADIUS, 32'h0);
        write_reg(REG_ENVELOPE, 32'hffffffff);
        send_vertex(32'sh10000, -32'sh10000, 32'sh10000, 17'h10000, 0);
        send_vertex(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 17'hffff, 0);
        end_burst();
        drain();

        // Long receiver hold-off while the sender keeps offering vertices.
        write_reg(REG_BULGE, 32'h8000);
        write_reg(REG_RADIUS, 32'h30000);
        write_reg(REG_ENVELOPE, 32'hc000);
        stall_long = 1'b1;
        for (int i = 0; i < 150; i++)
            send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_weight(), 0);
        end_burst();
        drain();

        // Random phases over several settings.
        random_phase(300);
        write_reg(REG_BULGE, 32'h0);
        write_reg(REG_RADIUS, 32'h7fffffff);
        write_reg(REG_ENVELOPE, 32'h0);
        random_phase(250);
        for (int p = 0; p < 5; p++)
        begin
            write_reg(REG_BULGE, $urandom_range(0, 17'h1ffff));
            write_reg(REG_RADIUS, $urandom);
            write_reg(REG_ENVELOPE, $urandom_range(0, 17'h1ffff));
            random_phase(250);
        end

        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/svd_pkg.sv
sv/svd_sqrt_cell.sv
sv/svd_div_cell.sv
sv/spherize_vertex_deform.sv
sv/svd_checker.sv
bench/spherize_vertex_deform_test.sv
